[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file for its checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pidl_pkg.sv]
// Package for the positional insert/delete list: field widths, codes,
// controller state and the command/flag structs. No dependencies.
package pidl_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4,
    OP_ROTATE = 3'd5
  } op_e;

  // Controller to datapath
  typedef struct packed {
    op_e     op;
    logic    load_out;
    logic    emit_entry;
    logic    last;
    status_e status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_bad;
    logic dump_last;
  } flags_t;

endpackage

[rtl/pidl_in_if.sv]
// Request channel: valid/ready handshake with kind, position and value.
// Depends on pidl_pkg.
interface pidl_in_if;
  import pidl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

[rtl/pidl_out_if.sv]
// Response channel: valid/ready handshake with status, value, count and last.
// Depends on pidl_pkg.
interface pidl_out_if;
  import pidl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] value_out;
  logic [COUNT_W-1:0]       count_out;
  logic                     last;

  modport source (output valid, status, value_out, count_out, last, input ready);
  modport sink   (input valid, status, value_out, count_out, last, output ready);
endinterface

[rtl/pidl_ctrl.sv]
// Controller for the list: decodes requests, sequences dumps, owns the
// response valid flag. Depends on pidl_pkg.
module pidl_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [pidl_pkg::KIND_W-1:0] kind_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  pidl_pkg::flags_t         flags_i,
  output pidl_pkg::cmd_t           cmd_o
);
  import pidl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;
  kind_e  kind;

  assign kind        = kind_e'(kind_i);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state: enter dump on a non-empty dump, leave after the last entry
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind == KIND_DUMP && !flags_i.empty) state_d = ST_DUMP;
      end
      ST_DUMP: begin
        if (slot_free && flags_i.dump_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: datapath command for this cycle
  always_comb begin
    cmd_o = '{op: OP_NONE, load_out: 1'b0, emit_entry: 1'b0, last: 1'b1, status: STAT_OK};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_CLEAR: begin
              cmd_o.op       = OP_CLEAR;
              cmd_o.load_out = 1'b1;
            end
            KIND_APPEND: begin
              cmd_o.load_out = 1'b1;
              if (flags_i.full) cmd_o.status = STAT_FULL;
              else              cmd_o.op     = OP_APPEND;
            end
            KIND_INSERT: begin
              cmd_o.load_out = 1'b1;
              if (flags_i.empty)        cmd_o.status = STAT_EMPTY;
              else if (flags_i.pos_bad) cmd_o.status = STAT_BADPOS;
              else if (flags_i.full)    cmd_o.status = STAT_FULL;
              else                      cmd_o.op     = OP_INSERT;
            end
            KIND_DELETE: begin
              cmd_o.load_out = 1'b1;
              if (flags_i.empty)        cmd_o.status = STAT_EMPTY;
              else if (flags_i.pos_bad) cmd_o.status = STAT_BADPOS;
              else                      cmd_o.op     = OP_DELETE;
            end
            KIND_DUMP: begin
              // Empty list answers at once; otherwise the dump state emits
              if (flags_i.empty) begin
                cmd_o.load_out = 1'b1;
                cmd_o.status   = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          cmd_o.op         = OP_ROTATE;
          cmd_o.load_out   = 1'b1;
          cmd_o.emit_entry = 1'b1;
          cmd_o.last       = flags_i.dump_last;
        end
      end
      default: ;
    endcase
  end

  // Hold the response beat until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/pidl_dp.sv]
// Datapath for the list: shifting register file, entry count, dump index
// and the response payload registers. Depends on pidl_pkg.
module pidl_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pidl_pkg::cmd_t                    cmd_i,
  output pidl_pkg::flags_t                  flags_o,
  input  logic [pidl_pkg::POS_W-1:0]        pos_i,
  input  logic signed [pidl_pkg::WORD_W-1:0] value_i,
  output logic [pidl_pkg::STATUS_W-1:0]     status_o,
  output logic signed [pidl_pkg::WORD_W-1:0] value_out_o,
  output logic [pidl_pkg::COUNT_W-1:0]      count_out_o,
  output logic                              last_o
);
  import pidl_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic signed [WORD_W-1:0] entries_q [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CMP_W-1:0]         cnt_x, pos_x;

  logic [STATUS_W-1:0]      status_q;
  logic signed [WORD_W-1:0] value_out_q;
  logic [COUNT_W-1:0]       count_out_q;
  logic                     last_q;

  assign cnt_x = CMP_W'(count_q);
  assign pos_x = CMP_W'(pos_i);

  // Status towards the controller
  assign flags_o.empty     = (count_q == '0);
  assign flags_o.full      = (count_q == CNT_W'(DEPTH));
  assign flags_o.pos_bad   = (pos_x >= cnt_x);
  assign flags_o.dump_last = (idx_q == IDX_W'(count_q - 1'b1));

  // Each entry selects from itself, its neighbours, entry zero or the new word
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [CMP_W-1:0] Idx     = CMP_W'(i);
    localparam logic [CMP_W-1:0] IdxNext = CMP_W'(i + 1);
    logic signed [WORD_W-1:0] upper, lower, entry_d;

    if (i == DEPTH - 1) begin : g_top
      assign upper = entries_q[i];
    end else begin : g_mid_up
      assign upper = entries_q[i+1];
    end
    if (i == 0) begin : g_bottom
      assign lower = entries_q[i];
    end else begin : g_mid_dn
      assign lower = entries_q[i-1];
    end

    always_comb begin
      entry_d = entries_q[i];
      case (cmd_i.op)
        OP_APPEND: if (Idx == cnt_x) entry_d = value_i;
        OP_INSERT: begin
          if (Idx == pos_x)     entry_d = value_i;
          else if (Idx > pos_x) entry_d = lower;
        end
        OP_DELETE: if (Idx >= pos_x) entry_d = upper;
        // Rotate the live entries down so each dump beat reads entry zero
        OP_ROTATE: begin
          if (IdxNext < cnt_x)       entry_d = upper;
          else if (IdxNext == cnt_x) entry_d = entries_q[0];
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk_i) begin
      entries_q[i] <= entry_d;
    end
  end

  // Advance the entry count
  always_comb begin
    case (cmd_i.op)
      OP_CLEAR:  count_d = '0;
      OP_APPEND: count_d = count_q + 1'b1;
      OP_INSERT: count_d = count_q + 1'b1;
      OP_DELETE: count_d = count_q - 1'b1;
      default:   count_d = count_q;
    endcase
  end

  // Dump index wraps to zero on the final beat of each dump
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.op == OP_ROTATE) idx_d = flags_o.dump_last ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Load the response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q    <= cmd_i.status;
      value_out_q <= cmd_i.emit_entry ? entries_q[0] : '0;
      count_out_q <= COUNT_W'(count_d);
      last_q      <= cmd_i.last;
    end
  end

  assign status_o    = status_q;
  assign value_out_o = value_out_q;
  assign count_out_o = count_out_q;
  assign last_o      = last_q;

endmodule

[rtl/positional_insert_delete_list.sv]
// Top level of the positional insert/delete list: controller plus datapath.
// Depends on pidl_pkg, pidl_in_if, pidl_out_if, pidl_ctrl, pidl_dp.
//
//   channel | dir | payload                              | handshake
//   req_i   | in  | kind, position, value                | valid/ready
//   rsp_o   | out | status, value_out, count_out, last   | valid/ready
//
// Clear, append, insert, delete and a dump of an empty list: the result
// beat is registered and shows the next cycle. Insert and delete shift the
// whole register file in the accepting cycle. A dump of n entries gives n
// beats, one per cycle while the response is not stalled, read from entry
// zero as the live entries rotate; no request is taken until the last beat
// is loaded. Reset clears the count and controller; entries hold until written.
// A stalled response holds its beat; a request is taken while it drains.
module positional_insert_delete_list #(
  parameter int unsigned DEPTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pidl_in_if.sink    req_i,
  pidl_out_if.source rsp_o
);
  import pidl_pkg::*;
  `include "assert_macros.svh"

  cmd_t   cmd;
  flags_t flags;
  logic   out_valid;

  pidl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .kind_i      (req_i.kind),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  pidl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .pos_i       (req_i.position),
    .value_i     (req_i.value),
    .status_o    (rsp_o.status),
    .value_out_o (rsp_o.value_out),
    .count_out_o (rsp_o.count_out),
    .last_o      (rsp_o.last)
  );

  assign rsp_o.valid = out_valid;

  // Checks on the controller/datapath interplay
  `ASSERT_IMPLY(a_accept_slot_free, clk_i, rst_ni, req_i.valid && req_i.ready, !rsp_o.valid || rsp_o.ready, "request taken while response slot blocked")
  `ASSERT_IMPLY(a_rotate_loads, clk_i, rst_ni, cmd.op == OP_ROTATE, cmd.load_out && cmd.emit_entry, "dump rotation without a response beat")
  `ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.load_out, rsp_o.valid, "loaded response not shown")
  `ASSERT_IMPLY(a_error_is_last, clk_i, rst_ni, rsp_o.valid && rsp_o.status != STAT_OK, rsp_o.last, "error beat not marked last")

endmodule
